FILE: rtl/core/ahns_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ahns_pkg
// shared types and constants of the additive harmonic note synthesizer
// ----------------------------------------------------------------------------
package ahns_pkg;

	localparam logic [1:0] FUNC_LOAD  = 2'd0;
	localparam logic [1:0] FUNC_START = 2'd1;
	localparam logic [1:0] FUNC_TICK  = 2'd2;
	localparam logic [1:0] FUNC_NOP   = 2'd3;

	localparam logic [2:0] REST_CODE = 3'd7;

	localparam int unsigned CFG_HARMONIC_COUNT = 0;

	// controller to datapath
	typedef struct packed {
		logic load;        // write coefficient slot
		logic start;       // take a new note
		logic clear;       // zero accumulator, reset harmonic phase
		logic accum;       // add one harmonic term
		logic finish;      // round, saturate, advance phase, count down
		logic finished;    // emit note finished result
	} ahns_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic note_done;   // samples left is zero
		logic rest;        // current note is a rest
		logic busy;        // terms still in the multiply-accumulate path
	} ahns_status_t;

	function automatic logic [31:0] base_step(input logic [2:0] note);
		logic [31:0] s;
		unique case (note)
			3'd0: s = 32'd25480551;
			3'd1: s = 32'd28600002;
			3'd2: s = 32'd32103176;
			3'd3: s = 32'd34012051;
			3'd4: s = 32'd38177487;
			3'd5: s = 32'd42852281;
			3'd6: s = 32'd48099738;
			default: s = 32'd0;
		endcase
		return s;
	endfunction

	// quarter-wave sine entry in Q14, built by integer taylor series
	function automatic logic [14:0] sine_entry(input int unsigned k, input int unsigned qn);
		logic [63:0] x;
		logic [63:0] term;
		longint sum;
		x = (64'(k) * 64'd1686629713) / 64'(qn);
		term = x;
		sum = longint'(x);
		for (int n = 1; n <= 7; n++) begin
			term = (term * x) >> 30;
			term = (term * x) >> 30;
			term = term / 64'((2 * n) * (2 * n + 1));
			if (n % 2 == 1) begin
				sum = sum - longint'(term);
			end else begin
				sum = sum + longint'(term);
			end
		end
		if (sum < 0) sum = 0;
		sum = (sum + 32768) >>> 16;
		if (sum > 16384) sum = 16384;
		return 15'(sum);
	endfunction

endpackage

`default_nettype wire

FILE: rtl/core/ahns_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ahns_in_if / ahns_out_if
// valid/ready channels of the synthesizer
// ----------------------------------------------------------------------------
interface ahns_in_if;
	logic               valid;
	logic               ready;
	logic [1:0]         func;
	logic [3:0]         harmonic_index;
	logic signed [15:0] real_coef;
	logic signed [15:0] imag_coef;
	logic [2:0]         note_code;
	logic [3:0]         octave_number;
	logic [15:0]        note_samples;
	modport source (output valid, func, harmonic_index, real_coef, imag_coef,
		note_code, octave_number, note_samples, input ready);
	modport sink (input valid, func, harmonic_index, real_coef, imag_coef,
		note_code, octave_number, note_samples, output ready);
endinterface

interface ahns_out_if;
	logic               valid;
	logic               ready;
	logic signed [23:0] sample_value;
	logic               note_finished;
	logic               clipped;
	modport source (output valid, sample_value, note_finished, clipped, input ready);
	modport sink (input valid, sample_value, note_finished, clipped, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/ahns_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ahns_ctrl
// sequencer: decodes items and steps the harmonic loop one term a cycle
// ----------------------------------------------------------------------------
module ahns_ctrl
	import ahns_pkg::*;
#(
	parameter int unsigned HARMONIC_SLOTS = 16,
	localparam int unsigned HW = $clog2(HARMONIC_SLOTS + 1)
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_ready,
	input  wire logic [1:0]   in_func,
	input  wire logic [HW-1:0] count,
	input  wire ahns_status_t status,
	output ahns_cmd_t         cmd,
	output logic              res_load,   // result register takes new value
	input  wire logic         res_free    // result register empty or draining
);

	typedef enum logic [1:0] {ST_IDLE, ST_SUM, ST_DONE} state_t;
	state_t state_q;
	logic [HW-1:0] h_q;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd = '0;
		res_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load  = (in_func == FUNC_LOAD);
					cmd.start = (in_func == FUNC_START);
					cmd.clear = (in_func == FUNC_TICK);
				end
			end
			ST_SUM: cmd.accum = (h_q < count) && !status.rest && !status.note_done;
			ST_DONE: begin
				// wait for the last terms to leave the accumulate path
				if (res_free && !status.busy) begin
					res_load = 1'b1;
					cmd.finish = !status.note_done;
					cmd.finished = status.note_done;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			h_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					h_q <= '0;
					if (in_valid && in_func == FUNC_TICK) begin
						state_q <= ST_SUM;
					end
				end
				ST_SUM: begin
					h_q <= h_q + 1'b1;
					if (h_q >= count || status.rest || status.note_done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: if (res_free && !status.busy) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/ahns_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ahns_datapath
// coefficient store, phase, sine lookup, multiply-accumulate, saturation
// ----------------------------------------------------------------------------
module ahns_datapath
	import ahns_pkg::*;
#(
	parameter int unsigned HARMONIC_SLOTS = 16,
	parameter int unsigned SINE_TABLE_BITS = 10,
	parameter int unsigned LENGTH_BITS = 16,
	localparam int unsigned SW = (HARMONIC_SLOTS > 1) ? $clog2(HARMONIC_SLOTS) : 1
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire ahns_cmd_t          cmd,
	output ahns_status_t            status,
	input  wire logic [3:0]         harmonic_index,
	input  wire logic signed [15:0] real_coef,
	input  wire logic signed [15:0] imag_coef,
	input  wire logic [2:0]         note_code,
	input  wire logic [3:0]         octave_number,
	input  wire logic [15:0]        note_samples,
	output logic signed [23:0]      sample_value,
	output logic                    note_finished,
	output logic                    clipped
);

	localparam int unsigned QB = SINE_TABLE_BITS - 2;
	localparam int unsigned QN = 1 << QB;
	localparam logic [LENGTH_BITS-1:0] LMAX = '1;

	logic [15:0] creal_mem [HARMONIC_SLOTS];
	logic [15:0] cimag_mem [HARMONIC_SLOTS];
	logic [2:0]  note_q;
	logic [31:0] step_q, phase_q, hphase_q;
	logic [LENGTH_BITS-1:0] left_q;
	logic [SW-1:0] rd_q;
	logic signed [15:0] cr_s1, ci_s1;
	logic [31:0] ph_s1;
	logic v_s1, v_s2;
	logic signed [31:0] pr_s2, pi_s2;
	logic signed [39:0] acc_q;
	logic [14:0] qtab [QN+1];

	// quarter-wave table, constant after elaboration
	for (genvar k = 0; k <= QN; k++) begin : g_qtab
		assign qtab[k] = sine_entry(k, QN);
	end

	function automatic logic signed [15:0] sine_of(input logic [31:0] p);
		logic [SINE_TABLE_BITS-1:0] idx;
		logic [QB:0] pos;
		logic [14:0] q;
		idx = p[31 -: SINE_TABLE_BITS];
		pos = {1'b0, idx[QB-1:0]};
		if (idx[QB]) pos = (QB+1)'(QN) - pos;
		q = qtab[pos];
		return idx[QB+1] ? -$signed({1'b0, q}) : $signed({1'b0, q});
	endfunction

	assign status.note_done = (left_q == '0);
	assign status.rest = (note_q == REST_CODE);
	assign status.busy = v_s1 || v_s2;

	// coefficient store, read address stepped by the accumulate command
	always_ff @(posedge clk) begin
		if (cmd.load && 32'(harmonic_index) < HARMONIC_SLOTS) begin
			creal_mem[SW'(harmonic_index)] <= real_coef;
			cimag_mem[SW'(harmonic_index)] <= imag_coef;
		end
		cr_s1 <= creal_mem[rd_q];
		ci_s1 <= cimag_mem[rd_q];
		ph_s1 <= hphase_q;
		pr_s2 <= cr_s1 * sine_of(ph_s1 + 32'h4000_0000);
		pi_s2 <= ci_s1 * sine_of(ph_s1);
	end

	logic [31:0] shifted;
	always_comb begin
		if (octave_number >= 4'd4) shifted = base_step(note_code) << (octave_number - 4'd4);
		else shifted = base_step(note_code) >> (4'd4 - octave_number);
	end

	logic signed [39:0] rnd;
	logic signed [25:0] v;
	assign rnd = acc_q + 40'sd8192;
	assign v = 26'(rnd >>> 14);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			note_q <= REST_CODE;
			step_q <= '0;
			phase_q <= '0;
			left_q <= '0;
			hphase_q <= '0;
			rd_q <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			acc_q <= '0;
		end else begin
			v_s1 <= cmd.accum;
			v_s2 <= v_s1;
			if (cmd.start) begin
				note_q <= note_code;
				step_q <= (note_code == REST_CODE) ? 32'd0 : shifted;
				phase_q <= '0;
				left_q <= (LENGTH_BITS >= 16) ? LENGTH_BITS'(note_samples) :
					((note_samples > 16'(LMAX)) ? LMAX : LENGTH_BITS'(note_samples));
			end
			if (cmd.clear) begin
				acc_q <= '0;
				rd_q <= '0;
				hphase_q <= phase_q;
			end else begin
				if (cmd.accum) begin
					rd_q <= rd_q + 1'b1;
					hphase_q <= hphase_q + phase_q;
				end
				if (v_s2) acc_q <= acc_q + 40'(pr_s2) - 40'(pi_s2);
			end
			if (cmd.finish) begin
				left_q <= left_q - 1'b1;
				phase_q <= phase_q + step_q;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			note_finished <= 1'b0;
			if (v > 26'sd8388607) begin
				sample_value <= 24'sh7FFFFF; clipped <= 1'b1;
			end else if (v < -26'sd8388608) begin
				sample_value <= -24'sd8388608; clipped <= 1'b1;
			end else begin
				sample_value <= 24'(v); clipped <= 1'b0;
			end
		end else if (cmd.finished) begin
			sample_value <= '0; note_finished <= 1'b1; clipped <= 1'b0;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/additive_harmonic_note_synth.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// additive_harmonic_note_synth
// one additive synthesis voice with a harmonic coefficient table
// ----------------------------------------------------------------------------
// input channel: a beat carries func; load beats write one harmonic slot,
// start beats set note, octave and length, tick beats ask for one sample.
// load and start beats give no result; the input stays ready after them.
// a tick beat walks the harmonics one per cycle through a three stage
// read / multiply / accumulate path; rests and finished notes skip the
// walk. the input stays unready until the sample is in the result register.
// output channel: one beat per tick, saturated sum rounded from 2^-14 units.
// the result register holds its beat while the receiver stalls; the input
// waits only until that register is free.
// reset clears note to rest, phase, step, length and sets harmonic_count 1;
// the coefficient store stays undefined until loaded.
// apb register 0 at address 0: harmonic_count; the user writes it only while idle, unchecked by the block.
// ----------------------------------------------------------------------------
module additive_harmonic_note_synth
	import ahns_pkg::*;
#(
	parameter int unsigned HARMONIC_SLOTS = 16,
	parameter int unsigned SINE_TABLE_BITS = 10,
	parameter int unsigned LENGTH_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	ahns_in_if.sink          in_ch,
	ahns_out_if.source       out_ch,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [1:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	localparam int unsigned HW = $clog2(HARMONIC_SLOTS + 1);

	logic [4:0] count_q;
	logic [HW-1:0] count_sat;
	logic out_valid_q, res_load, res_free;
	ahns_cmd_t cmd;
	ahns_status_t status;

	assign pready = 1'b1;
	assign prdata = (paddr == 2'(4 * CFG_HARMONIC_COUNT)) ? {27'd0, count_q} : 32'd0;
	assign count_sat = (32'(count_q) > HARMONIC_SLOTS) ? HW'(HARMONIC_SLOTS) : HW'(count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 5'd1;
			out_valid_q <= 1'b0;
		end else begin
			if (psel && penable && pwrite && paddr == 2'(4 * CFG_HARMONIC_COUNT))
				count_q <= pwdata[4:0];
			if (res_load) out_valid_q <= 1'b1;
			else if (out_ch.ready) out_valid_q <= 1'b0;
		end
	end

	assign res_free = !out_valid_q || out_ch.ready;
	assign out_ch.valid = out_valid_q;

	ahns_ctrl #(.HARMONIC_SLOTS(HARMONIC_SLOTS)) u_ctrl (
		.clk, .arst_n,
		.in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_func(in_ch.func),
		.count(count_sat), .status, .cmd, .res_load, .res_free
	);

	ahns_datapath #(
		.HARMONIC_SLOTS(HARMONIC_SLOTS), .SINE_TABLE_BITS(SINE_TABLE_BITS),
		.LENGTH_BITS(LENGTH_BITS)
	) u_dp (
		.clk, .arst_n, .cmd, .status,
		.harmonic_index(in_ch.harmonic_index), .real_coef(in_ch.real_coef),
		.imag_coef(in_ch.imag_coef), .note_code(in_ch.note_code),
		.octave_number(in_ch.octave_number), .note_samples(in_ch.note_samples),
		.sample_value(out_ch.sample_value), .note_finished(out_ch.note_finished),
		.clipped(out_ch.clipped)
	);

`ifndef NO_ASSERTIONS
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |-> !(cmd.load || cmd.start)) else $error("result during item decode");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ch.ready) |=> !res_load || out_ch.ready || !out_valid_q)
		else $error("result overwritten while stalled");
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_ch.note_finished && out_ch.clipped))
		else $error("finished beat marked clipped");
`endif

endmodule

`default_nettype wire
